/* design/assert_macros.svh */
// Assertion helpers shared by the display controller modules.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent this cycle implies consequent in the next.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SSD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* design/ssd_pkg.sv */
package ssd_pkg;

  localparam int MAX_DIGITS  = 8;
  localparam int DIGITS_DEF  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  BLANK_PAT  = 8'hFF;
  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [15:0] MAX_NUMBER = 16'd9999;
  localparam logic [15:0] MAX_VALUE  = 16'd9;

  typedef enum logic [2:0] {
    KIND_INIT,
    KIND_CLR_DIGIT,
    KIND_CLR_ALL,
    KIND_DIGIT,
    KIND_NUMBER,
    KIND_CHAR,
    KIND_TEXT,
    KIND_REFRESH
  } kind_t;

  // One decoded request: kind, error flag, lanes to write and the pattern for each lane.
  typedef struct packed {
    kind_t                            kind;
    logic                             bad;
    logic [MAX_DIGITS-1:0]            wr;
    logic [MAX_DIGITS-1:0][7:0]       pat;
  } op_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] pat;
  } char_t;

  function automatic logic [7:0] num_pat(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = BLANK_PAT;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] let_pat(input logic [4:0] idx);
    logic [7:0] p;
    case (idx)
      5'd0:    p = 8'h88;
      5'd1:    p = 8'h83;
      5'd2:    p = 8'hC6;
      5'd3:    p = 8'hA1;
      5'd4:    p = 8'h86;
      5'd5:    p = 8'h8E;
      5'd6:    p = 8'hC2;
      5'd7:    p = 8'h89;
      5'd8:    p = 8'hCF;
      5'd9:    p = 8'hE1;
      5'd10:   p = 8'h8A;
      5'd11:   p = 8'hC7;
      5'd12:   p = 8'hEA;
      5'd13:   p = 8'hC8;
      5'd14:   p = 8'hC0;
      5'd15:   p = 8'h8C;
      5'd16:   p = 8'h4A;
      5'd17:   p = 8'hCC;
      5'd18:   p = 8'h92;
      5'd19:   p = 8'h87;
      5'd20:   p = 8'hC1;
      5'd21:   p = 8'hC1;
      5'd22:   p = 8'hD5;
      5'd23:   p = 8'h89;
      5'd24:   p = 8'h91;
      5'd25:   p = 8'hA4;
      default: p = BLANK_PAT;
    endcase
    return p;
  endfunction

  function automatic char_t char_pat(input logic [7:0] c);
    char_t      r;
    logic [7:0] up;
    r.ok  = 1'b0;
    r.pat = BLANK_PAT;
    up    = (c >= 8'h61 && c <= 8'h7A) ? 8'(c - 8'd32) : c;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.pat = num_pat(4'(c - 8'h30));
    end else if (c == SPACE_CHAR) begin
      r.ok  = 1'b1;
      r.pat = BLANK_PAT;
    end else if (up >= 8'h41 && up <= 8'h5A) begin
      r.ok  = 1'b1;
      r.pat = let_pat(5'(up - 8'h41));
    end
    return r;
  endfunction

  function automatic logic [7:0] select_of(input logic [2:0] i);
    logic [7:0] s;
    if (i < 3'd4) begin
      s = 8'hF0 | (8'd1 << i[1:0]);
    end else begin
      s = 8'd1 << i;
    end
    return s;
  endfunction

endpackage

/* design/ssd_if.sv */
interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  digit;
  logic [15:0] number;
  logic [7:0]  char_code;
  logic [2:0]  text_len;
  logic [7:0]  text_char0;
  logic [7:0]  text_char1;
  logic [7:0]  text_char2;
  logic [7:0]  text_char3;

  modport source (
    output valid, kind, digit, number, char_code, text_len,
           text_char0, text_char1, text_char2, text_char3,
    input  ready
  );
  modport sink (
    input  valid, kind, digit, number, char_code, text_len,
           text_char0, text_char1, text_char2, text_char3,
    output ready
  );
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       is_frame;
  logic [7:0] frame_segments;
  logic [7:0] frame_select;
  logic       last;

  modport source (
    output valid, status, is_frame, frame_segments, frame_select, last,
    input  ready
  );
  modport sink (
    input  valid, status, is_frame, frame_segments, frame_select, last,
    output ready
  );
endinterface

/* design/seven_segment_display_controller.sv */
// Multiplexed seven-segment display controller, active-low segments.
// in_ch carries host requests (init, clear digit, clear all, digit value,
// number, character, text, refresh); out_ch carries results. Each request
// gives one status result with last set, except refresh on an initialised
// display, which gives DIGITS frames (segment byte, select byte) and then a
// blank frame with last set.
// A status result is registered in the output register after its request
// has passed through the queue. A number write first stays in the front
// with in_ch.ready low: three compare-and-subtract steps (the units fall out
// of the last) and a hold state that hands it to the queue once it has room.
// Throughput: one request per cycle while the queue has room; a number write
// is not followed by another request until it is handed over. Refresh holds
// the back end for DIGITS + 1 frames, one frame per cycle while out_ch is ready.
// A two-entry request queue lets the front keep taking requests while the
// back end is busy or the receiver stalls; a stalled result is held in the
// output register and the queue fills before in_ch.ready drops.
// Reset is synchronous: it blanks every digit and clears the initialised flag;
// outputs go invalid on a clock edge with rst_n low.
module seven_segment_display_controller #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_ch,
  ssd_out_if.source  out_ch
);

  logic         push;
  ssd_pkg::op_t push_op;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  ssd_pkg::op_t q_op;

  ssd_front #(.DIGITS(DIGITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .push    (push),
    .push_op (push_op),
    .q_full  (q_full)
  );

  ssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_op)
  );

  ssd_back #(.DIGITS(DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* design/ssd_queue.sv */
`include "assert_macros.svh"

module ssd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssd_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ssd_pkg::op_t  head_op
);

  localparam int PTR_W = $clog2(ssd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ssd_pkg::QUEUE_DEPTH + 1);

  ssd_pkg::op_t     mem [ssd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(ssd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `SSD_ASSERT(a_no_overflow, push |-> !full || pop, "request pushed into full queue")
  `SSD_ASSERT(a_no_underflow, pop |-> head_valid, "pop from empty queue")

endmodule

/* design/ssd_front.sv */
module ssd_front #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ssd_in_if.sink        in_ch,
  output logic          push,
  output ssd_pkg::op_t  push_op,
  input  logic          q_full
);

  typedef enum logic [1:0] {F_IDLE, F_SPLIT, F_HOLD} fstate_t;

  localparam logic [9:0] PLACE [3] = '{10'd1000, 10'd100, 10'd10};
  localparam logic [1:0] LAST_STEP = 2'd2;

  fstate_t      state_r;
  logic [1:0]   step_r;
  logic [13:0]  rem_r;
  logic [13:0]  rem_nxt;
  logic [3:0]   dval;
  ssd_pkg::op_t op_r;
  ssd_pkg::op_t dec_op;
  logic         in_fire;
  logic         need_split;

  assign in_ch.ready = (state_r == F_IDLE) && !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign need_split  = (ssd_pkg::kind_t'(in_ch.kind) == ssd_pkg::KIND_NUMBER) &&
                       (in_ch.number <= ssd_pkg::MAX_NUMBER);

  assign push    = (in_fire && !need_split) || (state_r == F_HOLD && !q_full);
  assign push_op = (state_r == F_HOLD) ? op_r : dec_op;

  // One decimal digit per step: count how many place values fit.
  always_comb begin
    logic [13:0] place;
    place = 14'(PLACE[step_r]);
    dval  = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_r >= 14'(k) * place) begin
        dval = 4'(k);
      end
    end
    rem_nxt = rem_r - 14'(place * 14'(dval));
  end

  always_comb begin
    logic [7:0]           tc [4];
    logic [2:0]           len_sat;
    logic                 live;
    logic                 take;
    logic [7:0]           tx;
    ssd_pkg::char_t       cp;
    logic                 dig_bad;
    logic [7:0]           dsel;
    tc[0]   = in_ch.text_char0;
    tc[1]   = in_ch.text_char1;
    tc[2]   = in_ch.text_char2;
    tc[3]   = in_ch.text_char3;
    len_sat = (in_ch.text_len > 3'd4) ? 3'd4 : in_ch.text_len;
    dig_bad = (32'(in_ch.digit) >= DIGITS);
    dsel    = 8'd1 << in_ch.digit;
    cp      = ssd_pkg::char_pat(in_ch.char_code);
    live    = 1'b1;
    take    = 1'b0;
    tx      = ssd_pkg::SPACE_CHAR;

    dec_op.kind = ssd_pkg::kind_t'(in_ch.kind);
    dec_op.bad  = 1'b0;
    dec_op.wr   = '0;
    dec_op.pat  = {ssd_pkg::MAX_DIGITS{ssd_pkg::BLANK_PAT}};

    case (ssd_pkg::kind_t'(in_ch.kind))
      ssd_pkg::KIND_CLR_DIGIT: begin
        dec_op.bad = dig_bad;
        dec_op.wr  = dsel;
      end
      ssd_pkg::KIND_CLR_ALL: begin
        dec_op.wr = '1;
      end
      ssd_pkg::KIND_DIGIT: begin
        dec_op.bad = dig_bad || (in_ch.number > ssd_pkg::MAX_VALUE);
        dec_op.wr  = dsel;
        dec_op.pat = {ssd_pkg::MAX_DIGITS{ssd_pkg::num_pat(in_ch.number[3:0])}};
      end
      ssd_pkg::KIND_NUMBER: begin
        // Only the out-of-range case leaves from here; the rest is split.
        dec_op.bad = 1'b1;
      end
      ssd_pkg::KIND_CHAR: begin
        dec_op.bad = dig_bad || !cp.ok;
        dec_op.wr  = dsel;
        dec_op.pat = {ssd_pkg::MAX_DIGITS{cp.pat}};
      end
      ssd_pkg::KIND_TEXT: begin
        // Pad with spaces after the length or the first zero byte.
        for (int i = 0; i < 4; i++) begin
          take  = live && (3'(i) < len_sat) && (tc[i] != 8'h00);
          live  = take;
          tx    = take ? tc[i] : ssd_pkg::SPACE_CHAR;
          cp    = ssd_pkg::char_pat(tx);
          dec_op.wr[i]  = cp.ok;
          dec_op.pat[i] = cp.pat;
        end
      end
      default: begin
        dec_op.wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_fire && need_split) begin
            state_r     <= F_SPLIT;
            step_r      <= '0;
            rem_r       <= in_ch.number[13:0];
            op_r.kind   <= ssd_pkg::KIND_NUMBER;
            op_r.bad    <= 1'b0;
            op_r.wr     <= ssd_pkg::MAX_DIGITS'(4'hF);
            op_r.pat    <= {ssd_pkg::MAX_DIGITS{ssd_pkg::BLANK_PAT}};
          end
        end
        F_SPLIT: begin
          rem_r                  <= rem_nxt;
          op_r.pat[{1'b0, step_r}] <= ssd_pkg::num_pat(dval);
          if (step_r == LAST_STEP) begin
            op_r.pat[3] <= ssd_pkg::num_pat(rem_nxt[3:0]);
            state_r     <= F_HOLD;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        F_HOLD: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/ssd_back.sv */
`include "assert_macros.svh"

module ssd_back #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ssd_pkg::op_t  q_op,
  output logic          q_pop,
  ssd_out_if.source     out_ch
);

  typedef enum logic {B_IDLE, B_FRAMES} bstate_t;

  localparam int CNT_W = $clog2(DIGITS + 1);
  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  bstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ready_r;
  logic [7:0]       pat_r [DIGITS];
  logic             out_valid_r;
  logic             status_r;
  logic             is_frame_r;
  logic [7:0]       seg_r;
  logic [7:0]       sel_r;
  logic             last_r;

  logic             ld;
  logic             is_refresh;
  logic             issue;
  logic             err;
  logic             commit;
  logic             frames_done;

  assign ld          = !out_valid_r || out_ch.ready;
  assign is_refresh  = (q_op.kind == ssd_pkg::KIND_REFRESH) && ready_r;
  assign issue       = (state_r == B_IDLE) && q_valid && ld && !is_refresh;
  assign frames_done = (cnt_r == CNT_W'(DIGITS));
  assign q_pop       = issue || (state_r == B_FRAMES && ld && frames_done);
  assign commit      = issue && ready_r && !q_op.bad &&
                       (q_op.kind != ssd_pkg::KIND_INIT) &&
                       (q_op.kind != ssd_pkg::KIND_REFRESH);

  always_comb begin
    case (q_op.kind)
      ssd_pkg::KIND_INIT:    err = ready_r;
      ssd_pkg::KIND_CLR_ALL: err = 1'b0;
      default:               err = !ready_r || q_op.bad;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.is_frame       = is_frame_r;
  assign out_ch.frame_segments = seg_r;
  assign out_ch.frame_select   = sel_r;
  assign out_ch.last           = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        pat_r[i] <= ssd_pkg::BLANK_PAT;
      end
    end else begin
      for (int i = 0; i < DIGITS; i++) begin
        if (commit && q_op.wr[i]) begin
          pat_r[i] <= q_op.pat[i];
        end
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid && ld) begin
            out_valid_r <= 1'b1;
            if (is_refresh) begin
              // Send the first frame now; hold the request until the blank frame.
              status_r   <= 1'b0;
              is_frame_r <= 1'b1;
              seg_r      <= pat_r[0];
              sel_r      <= ssd_pkg::select_of(3'd0);
              last_r     <= 1'b0;
              cnt_r      <= CNT_W'(1);
              state_r    <= B_FRAMES;
            end else begin
              status_r   <= err;
              is_frame_r <= 1'b0;
              seg_r      <= '0;
              sel_r      <= '0;
              last_r     <= 1'b1;
              if (q_op.kind == ssd_pkg::KIND_INIT && !ready_r) begin
                ready_r <= 1'b1;
              end
            end
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        B_FRAMES: begin
          if (ld) begin
            out_valid_r <= 1'b1;
            status_r    <= 1'b0;
            is_frame_r  <= 1'b1;
            if (frames_done) begin
              seg_r   <= ssd_pkg::BLANK_PAT;
              sel_r   <= ssd_pkg::select_of(3'(DIGITS - 1));
              last_r  <= 1'b1;
              state_r <= B_IDLE;
            end else begin
              seg_r  <= pat_r[cnt_r[IDX_W-1:0]];
              sel_r  <= ssd_pkg::select_of(3'(cnt_r));
              last_r <= 1'b0;
              cnt_r  <= cnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  `SSD_ASSERT_NEXT(a_init_sticky, ready_r, ready_r, "initialised flag dropped")
  `SSD_ASSERT(a_frames_need_init, (state_r == B_FRAMES) |-> ready_r && q_valid,
              "refresh frames without an initialised display")
  `SSD_ASSERT(a_cnt_bound, (state_r == B_FRAMES) |-> (cnt_r <= CNT_W'(DIGITS)),
              "frame counter past blank frame")

endmodule
